// File: hw/rtl/dpd_pkg.sv
// Shared types, constants and helpers for the debug packet deframer.
package dpd_pkg;

    localparam int MAX_PAYLOAD = 2047;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int LEN_W       = 11;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ACK   = 8'h2B;
    localparam logic [7:0] CH_NAK   = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_TX      = 2'd1,
        KIND_DISCARD = 2'd2
    } kind_t;

    localparam logic CAUSE_RESTART  = 1'b0;
    localparam logic CAUSE_OVERFLOW = 1'b1;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             good;
        logic             seq;
        logic             cause;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [1:0]      count;
        res_t [2:0]      res;
    } burst_t;

    function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+LEN_W-1:0] wide;
        wide = {{LEN_W{1'b0}}, cnt};
        return wide[LEN_W-1:0];
    endfunction

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'hFF;
        if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v;
    endfunction

    function automatic res_t mk_res(input kind_t kind, input logic [7:0] data,
                                    input logic [LEN_W-1:0] len, input logic good,
                                    input logic seq, input logic cause,
                                    input logic last);
        res_t r;
        r.kind  = kind;
        r.data  = data;
        r.len   = len;
        r.good  = good;
        r.seq   = seq;
        r.cause = cause;
        r.last  = last;
        return r;
    endfunction

endpackage

// File: hw/rtl/dpd_core.sv
// Packet parser state and per-byte result burst generation.
module dpd_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    output dpd_pkg::burst_t  burst
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_HIGH    = 4'b0100,
        PH_LOW     = 4'b1000
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  sum_reg, sum_next;
    logic [dpd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]                  head_reg [3];
    logic [7:0]                  head_next [3];
    logic [7:0]                  high_reg, high_next;
    logic [dpd_pkg::CNT_W-1:0]   cnt_inc;
    logic [7:0]                  dv;
    logic [7:0]                  sent;
    logic                        seq;

    assign cnt_inc = cnt_reg + 1'b1;
    assign dv      = dpd_pkg::digit_value(rx_byte);
    assign sent    = high_reg + dv;
    assign seq     = (cnt_reg >= dpd_pkg::CNT_W'(3)) && (head_reg[2] == dpd_pkg::CH_COLON);

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        high_next  = high_reg;
        for (int i = 0; i < 3; i++) begin
            head_next[i] = head_reg[i];
        end
        burst = '0;
        case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == dpd_pkg::CH_START) begin
                    phase_next = PH_PAYLOAD;
                    sum_next   = '0;
                    cnt_next   = '0;
                end
            end
            PH_PAYLOAD: begin
                if (rx_byte == dpd_pkg::CH_START) begin
                    burst.count  = 2'd1;
                    burst.res[0] = dpd_pkg::mk_res(dpd_pkg::KIND_DISCARD, 8'h00,
                        dpd_pkg::len_of(cnt_reg), 1'b0, 1'b0, dpd_pkg::CAUSE_RESTART, 1'b1);
                    sum_next = '0;
                    cnt_next = '0;
                end else if (rx_byte == dpd_pkg::CH_HASH) begin
                    phase_next = PH_HIGH;
                end else begin
                    sum_next = sum_reg + rx_byte;
                    if (cnt_reg < dpd_pkg::CNT_W'(3)) begin
                        head_next[cnt_reg[1:0]] = rx_byte;
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc == dpd_pkg::CNT_W'(dpd_pkg::MAX_PAYLOAD)) begin
                        burst.count  = 2'd2;
                        burst.res[0] = dpd_pkg::mk_res(dpd_pkg::KIND_PAYLOAD, rx_byte,
                            dpd_pkg::len_of(cnt_inc), 1'b0, 1'b0, 1'b0, 1'b0);
                        burst.res[1] = dpd_pkg::mk_res(dpd_pkg::KIND_DISCARD, 8'h00,
                            dpd_pkg::len_of(cnt_inc), 1'b0, 1'b0,
                            dpd_pkg::CAUSE_OVERFLOW, 1'b1);
                        phase_next = PH_IDLE;
                    end else begin
                        burst.count  = 2'd1;
                        burst.res[0] = dpd_pkg::mk_res(dpd_pkg::KIND_PAYLOAD, rx_byte,
                            dpd_pkg::len_of(cnt_inc), 1'b0, 1'b0, 1'b0, 1'b1);
                    end
                end
            end
            PH_HIGH: begin
                high_next  = {dv[3:0], 4'h0};
                phase_next = PH_LOW;
            end
            PH_LOW: begin
                if (sent == sum_reg) begin
                    burst.res[0] = dpd_pkg::mk_res(dpd_pkg::KIND_TX, dpd_pkg::CH_ACK,
                        dpd_pkg::len_of(cnt_reg), 1'b1, seq, 1'b0, !seq);
                    burst.res[1] = dpd_pkg::mk_res(dpd_pkg::KIND_TX, head_reg[0],
                        dpd_pkg::len_of(cnt_reg), 1'b1, 1'b1, 1'b0, 1'b0);
                    burst.res[2] = dpd_pkg::mk_res(dpd_pkg::KIND_TX, head_reg[1],
                        dpd_pkg::len_of(cnt_reg), 1'b1, 1'b1, 1'b0, 1'b1);
                    burst.count  = seq ? 2'd3 : 2'd1;
                end else begin
                    burst.count  = 2'd1;
                    burst.res[0] = dpd_pkg::mk_res(dpd_pkg::KIND_TX, dpd_pkg::CH_NAK,
                        dpd_pkg::len_of(cnt_reg), 1'b0, 1'b0, 1'b0, 1'b1);
                end
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            high_reg  <= '0;
            for (int i = 0; i < 3; i++) begin
                head_reg[i] <= '0;
            end
        end else if (accept) begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            high_reg  <= high_next;
            for (int i = 0; i < 3; i++) begin
                head_reg[i] <= head_next[i];
            end
        end
    end

endmodule

// File: hw/rtl/dpd_outbuf.sv
// Result burst register that hands out up to three results, one per cycle while m_ready is high.
module dpd_outbuf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dpd_pkg::burst_t  burst,
    output logic             m_valid,
    input  logic             m_ready,
    output dpd_pkg::res_t    m_res
);

    dpd_pkg::res_t  ent_reg [3];
    logic [1:0]     cnt_reg;
    logic           pop;
    logic           load;

    assign m_valid = (cnt_reg != 2'd0);
    assign m_res   = ent_reg[0];
    assign pop     = m_valid && m_ready;
    assign s_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign load    = s_valid && s_ready && (burst.count != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= burst.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < 3; i++) begin
                ent_reg[i] <= burst.res[i];
            end
        end else if (pop) begin
            ent_reg[0] <= ent_reg[1];
            ent_reg[1] <= ent_reg[2];
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3 || !s_ready)
        else $error("buffer accepts while holding a full burst");

    a_last_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_res.last == (cnt_reg == 2'd1)))
        else $error("last flag out of step with buffer count");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !load) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("buffer count did not drop after a pop");

endmodule

// File: hw/rtl/debug_packet_deframer.sv
// Top level of the debug packet deframer: byte stream in, event stream out.
// Each received byte is parsed in the cycle it is accepted and yields zero to
// three result requests (payload byte, discard, ack/nak plus echoed sequence
// id), which are held in a three-entry burst register and sent one per
// cycle while m_tready is high. A new byte is accepted every cycle while
// the previous byte's results are drained by the cycle of acceptance, so
// the rate is one byte per cycle; a byte with several results stalls the
// input until all but the last are taken. No clearing pass after reset.
module debug_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [18:8] payload_length,
                                   // [19] checksum_good, [20] seq_present,
                                   // [21] discard_cause, [23:22] zero
    output logic [1:0]  m_tuser,   // [1:0] event_kind
    output logic        m_tlast
);

    dpd_pkg::burst_t burst;
    dpd_pkg::res_t   res;

    dpd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_tvalid && s_tready),
        .rx_byte (s_tdata),
        .burst   (burst)
    );

    dpd_outbuf u_outbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .burst   (burst),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    assign m_tdata = {2'b00, res.cause, res.seq, res.good, res.len, res.data};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

// File: test/debug_packet_deframer_tb.sv
// Self-checking testbench for debug_packet_deframer: random and directed byte streams.
module debug_packet_deframer_tb;

    typedef logic [7:0] octet_t;
    typedef enum logic [1:0] {ST_IDLE, ST_PAYLOAD, ST_HIGH, ST_LOW} rx_phase_t;
    typedef enum int {CK_GOOD, CK_BAD, CK_JUNK_HIGH, CK_JUNK_LOW} cksum_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    debug_packet_deframer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    octet_t           rx_bytes_pending[$];
    dpd_pkg::res_t    expected_events[$];
    int        send_idle_pct = 13;
    int        recv_idle_pct = 50;
    int        n_queued = 0;
    int        n_accepted = 0;
    int        errors = 0;
    int        n_payload_ev = 0;
    int        n_tx_ev = 0;
    int        n_discard_ev = 0;

    rx_phase_t      rx_phase = ST_IDLE;
    logic [7:0]     rx_sum = 8'h00;
    int             rx_count = 0;
    octet_t         rx_head[3] = '{8'h00, 8'h00, 8'h00};
    logic [7:0]     rx_high = 8'h00;

    function automatic logic [7:0] digit_of(input octet_t c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 8'd10;
        if (c >= "a" && c <= "f") return c - "a" + 8'd10;
        return 8'hFF;
    endfunction

    function automatic octet_t hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) return 8'h30 + nib;
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic octet_t non_hex_char();
        octet_t c;
        c = 8'($urandom_range(255));
        while (digit_of(c) != 8'hFF) c = 8'($urandom_range(255));
        return c;
    endfunction

    task automatic expect_event(input dpd_pkg::kind_t kind, input octet_t data, input int len,
                                input logic good, input logic seq, input logic cause);
        dpd_pkg::res_t r;
        r.kind  = kind;
        r.data  = data;
        r.len   = dpd_pkg::LEN_W'(len);
        r.good  = good;
        r.seq   = seq;
        r.cause = cause;
        r.last  = 1'b0;
        expected_events.push_back(r);
    endtask

    task automatic predict_byte(input octet_t c);
        int         first;
        logic [7:0] dv;
        logic [7:0] sent;
        logic       echo;
        first = expected_events.size();
        case (rx_phase)
            ST_IDLE: begin
                if (c == dpd_pkg::CH_START) begin
                    rx_phase = ST_PAYLOAD;
                    rx_sum   = 8'h00;
                    rx_count = 0;
                end
            end
            ST_PAYLOAD: begin
                if (c == dpd_pkg::CH_START) begin
                    expect_event(dpd_pkg::KIND_DISCARD, 8'h00, rx_count, 1'b0, 1'b0,
                                 dpd_pkg::CAUSE_RESTART);
                    rx_sum   = 8'h00;
                    rx_count = 0;
                end else if (c == dpd_pkg::CH_HASH) begin
                    rx_phase = ST_HIGH;
                end else begin
                    rx_sum = rx_sum + c;
                    if (rx_count < 3) rx_head[rx_count] = c;
                    rx_count++;
                    expect_event(dpd_pkg::KIND_PAYLOAD, c, rx_count, 1'b0, 1'b0, 1'b0);
                    if (rx_count >= dpd_pkg::MAX_PAYLOAD) begin
                        expect_event(dpd_pkg::KIND_DISCARD, 8'h00, rx_count, 1'b0, 1'b0,
                                     dpd_pkg::CAUSE_OVERFLOW);
                        rx_phase = ST_IDLE;
                    end
                end
            end
            ST_HIGH: begin
                dv       = digit_of(c);
                rx_high  = {dv[3:0], 4'h0};
                rx_phase = ST_LOW;
            end
            default: begin
                sent = rx_high + digit_of(c);
                if (sent == rx_sum) begin
                    echo = (rx_count >= 3) && (rx_head[2] == dpd_pkg::CH_COLON);
                    expect_event(dpd_pkg::KIND_TX, dpd_pkg::CH_ACK, rx_count, 1'b1, echo,
                                 1'b0);
                    if (echo) begin
                        expect_event(dpd_pkg::KIND_TX, rx_head[0], rx_count, 1'b1, 1'b1,
                                     1'b0);
                        expect_event(dpd_pkg::KIND_TX, rx_head[1], rx_count, 1'b1, 1'b1,
                                     1'b0);
                    end
                end else begin
                    expect_event(dpd_pkg::KIND_TX, dpd_pkg::CH_NAK, rx_count, 1'b0, 1'b0,
                                 1'b0);
                end
                rx_phase = ST_IDLE;
            end
        endcase
        if (expected_events.size() > first)
            expected_events[expected_events.size() - 1].last = 1'b1;
    endtask

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (rx_bytes_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_bytes_pending.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check the output side first, then predict from the input side
    always @(posedge aclk) begin
        dpd_pkg::res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result request: kind %0d data 0x%0h len %0d",
                           m_tuser, m_tdata[7:0], m_tdata[18:8]);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", want.kind, m_tuser);
                    check_field("data_byte", want.data, m_tdata[7:0]);
                    check_field("payload_length", want.len, m_tdata[18:8]);
                    check_field("checksum_good", want.good, m_tdata[19]);
                    check_field("seq_present", want.seq, m_tdata[20]);
                    check_field("discard_cause", want.cause, m_tdata[21]);
                    check_field("last", want.last, m_tlast);
                    case (want.kind)
                        dpd_pkg::KIND_PAYLOAD: n_payload_ev++;
                        dpd_pkg::KIND_TX:      n_tx_ev++;
                        default:               n_discard_ev++;
                    endcase
                end
            end
            if (s_tvalid && s_tready) begin
                predict_byte(s_tdata);
                n_accepted++;
            end
        end
    end

    task automatic send_byte(input octet_t c);
        rx_bytes_pending.push_back(c);
        n_queued++;
    endtask

    task automatic send_frame(input octet_t body[$], input octet_t hi, input octet_t lo);
        send_byte(dpd_pkg::CH_START);
        foreach (body[i]) send_byte(body[i]);
        send_byte(dpd_pkg::CH_HASH);
        send_byte(hi);
        send_byte(lo);
    endtask

    function automatic logic [7:0] sum_of(input octet_t body[$]);
        logic [7:0] s;
        s = 8'h00;
        foreach (body[i]) s = s + body[i];
        return s;
    endfunction

    task automatic send_checked_frame(input octet_t body[$], input cksum_mode_t mode);
        logic [7:0] ck;
        bit         upper;
        ck    = sum_of(body);
        upper = 1'($urandom_range(1));
        case (mode)
            CK_GOOD:      send_frame(body, hex_char(ck[7:4], upper), hex_char(ck[3:0], upper));
            CK_BAD: begin
                ck = ck + 8'($urandom_range(1, 255));
                send_frame(body, hex_char(ck[7:4], upper), hex_char(ck[3:0], upper));
            end
            CK_JUNK_HIGH: send_frame(body, non_hex_char(), hex_char(ck[3:0], upper));
            default:      send_frame(body, hex_char(ck[7:4], upper), non_hex_char());
        endcase
    endtask

    function automatic octet_t body_byte();
        octet_t c;
        c = 8'($urandom_range(255));
        if (c == dpd_pkg::CH_START || c == dpd_pkg::CH_HASH) c = c ^ 8'h40;
        return c;
    endfunction

    task automatic send_random_frame();
        octet_t      body[$];
        int          len;
        int          pick;
        cksum_mode_t mode;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        if ($urandom_range(9) == 0) begin
            send_byte(dpd_pkg::CH_START);
            repeat ($urandom_range(0, 4)) send_byte(body_byte());
        end
        len = ($urandom_range(99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        for (int i = 0; i < len; i++) body.push_back(body_byte());
        if (len >= 3 && $urandom_range(3) != 0) body[2] = dpd_pkg::CH_COLON;
        if ($urandom_range(19) == 0) begin
            // truncated frame: no checksum, next start char restarts it
            send_byte(dpd_pkg::CH_START);
            foreach (body[i]) send_byte(body[i]);
            return;
        end
        pick = $urandom_range(9);
        mode = (pick < 7) ? CK_GOOD : (pick == 7) ? CK_BAD : (pick == 8) ? CK_JUNK_HIGH
                                                                         : CK_JUNK_LOW;
        send_checked_frame(body, mode);
    endtask

    task automatic send_random_phase(input int count);
        int base;
        base = n_queued;
        while (n_queued - base < count) send_random_frame();
    endtask

    task automatic wait_all_results();
        @(negedge aclk);
        while (n_accepted < n_queued || expected_events.size() != 0) @(negedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // sequence id echo, uppercase/lowercase at random
        send_checked_frame('{"1", "2", ":", "Z"}, CK_GOOD);
        // restart by start char, then empty payload with stale ':' in the head buffer
        send_byte(dpd_pkg::CH_START);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame('{}, "0", "0");
        // hash as high digit gives 0xF0, start char as low digit adds 0xFF
        send_frame('{8'hF5}, dpd_pkg::CH_HASH, "5");
        send_frame('{8'h0F}, "1", dpd_pkg::CH_START);
        send_frame('{"a"}, "0", "0");

        wait_all_results();
        send_random_phase(100);
        wait_all_results();

        send_idle_pct = 50;
        recv_idle_pct = 13;
        send_random_phase(100);
        wait_all_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_phase(100);
        wait_all_results();
        repeat (20) @(posedge aclk);

        $display("Run covered %0d received bytes: %0d payload, %0d transmit, %0d discard events.",
                 n_accepted, n_payload_ev, n_tx_ev, n_discard_ev);
        $display("Included restarts, sequence-id echo, non-hex digits and short payloads.");
        if (errors == 0 && expected_events.size() == 0) begin
            $display("** debug_packet_deframer: PASSED **");
        end else begin
            $display("** debug_packet_deframer: FAILED **");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout: %0d results still expected", expected_events.size());
        $display("** debug_packet_deframer: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dpd_pkg.sv
hw/rtl/dpd_core.sv
hw/rtl/dpd_outbuf.sv
hw/rtl/debug_packet_deframer.sv
test/debug_packet_deframer_tb.sv
